/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the day/night mode controller.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/dnmc_pkg.sv */
// Package for the day/night mode controller: item types, register indexes,
// reset values and the schedule distance functions. No dependencies.
package dnmc_pkg;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  // Calendar constants.
  localparam int unsigned MINUTES_PER_DAY  = 1440;
  localparam int unsigned MINUTES_PER_HOUR = 60;

  // Register reset values.
  localparam logic [11:0] THRESHOLD_RST   = 12'd2048;
  localparam logic [10:0] DAY_START_RST   = 11'd420;
  localparam logic [10:0] NIGHT_START_RST = 11'd1320;
  localparam logic [7:0]  DAY_BRIGHT_RST  = 8'd150;
  localparam logic [7:0]  NIGHT_BRIGHT_RST = 8'd50;
  localparam logic [11:0] DAY_SPEED_RST   = 12'd256;
  localparam logic [11:0] NIGHT_SPEED_RST = 12'd256;
  localparam logic [15:0] HOLDOFF_RST     = 16'(10 * 1000);

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIGHT_THRESHOLD    = 4'd0,
    REG_DAY_START_MINUTE   = 4'd1,
    REG_NIGHT_START_MINUTE = 4'd2,
    REG_DAY_BRIGHTNESS     = 4'd3,
    REG_NIGHT_BRIGHTNESS   = 4'd4,
    REG_DAY_SPEED          = 4'd5,
    REG_NIGHT_SPEED        = 4'd6,
    REG_HOLDOFF_MS         = 4'd7
  } cfg_reg_t;

  // Kind of input item.
  typedef enum logic {
    ACT_LIGHT = 1'b0,
    ACT_SCHED = 1'b1
  } action_t;

  typedef struct packed {
    action_t     action;
    logic [11:0] sample;
    logic [31:0] now_ms;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } in_item_t;

  typedef struct packed {
    logic        night_mode;
    logic        mode_changed;
    logic [7:0]  brightness;
    logic [11:0] speed_factor;
    logic [11:0] average_level;
    logic        scheduled_night;
    logic [10:0] next_check_minutes;
  } out_item_t;

  // Minute of day; out-of-range hours and minutes give up to 1923.
  function automatic logic [10:0] minute_of_day(input logic [4:0] hour,
                                                input logic [5:0] minute);
    minute_of_day = 11'(hour) * 11'(MINUTES_PER_HOUR) + 11'(minute);
  endfunction

  // Minutes from cur to start, modulo one day, with zero read as a full day.
  // The biased difference stays below 4928, so after subtracting two days
  // it is under two days and one more conditional subtraction finishes.
  function automatic logic [10:0] dist_to(input logic [10:0] start,
                                          input logic [10:0] cur);
    logic [12:0] x;
    x = 13'(start) + 13'(2 * MINUTES_PER_DAY) - 13'(cur);
    if (x >= 13'(2 * MINUTES_PER_DAY)) begin
      x = x - 13'(2 * MINUTES_PER_DAY);
    end
    if (x >= 13'(MINUTES_PER_DAY)) begin
      x = x - 13'(MINUTES_PER_DAY);
    end
    if (x == 13'd0) begin
      x = 13'(MINUTES_PER_DAY);
    end
    dist_to = x[10:0];
  endfunction

endpackage

/* rtl/dnmc_window.sv */
// Moving-average window of light readings: shift line, running sum and
// a reciprocal multiply for the average. Depends on dnmc_pkg.
module dnmc_window
  import dnmc_pkg::*;
#(
  parameter int unsigned WINDOW = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        shift_en,
  input  logic [11:0] sample_in,
  output logic [11:0] avg_level,
  output logic [11:0] avg_level_nxt
);

  // The sum of WINDOW 12-bit readings never wraps in SUM_W bits.
  localparam int unsigned LOG_W = $clog2(WINDOW);
  localparam int unsigned SUM_W = 12 + LOG_W;
  // Reciprocal with shift SHIFT is exact for every sum below 2^SUM_W.
  localparam int unsigned SHIFT = SUM_W + LOG_W;
  localparam int unsigned RECIP = ((1 << SHIFT) + WINDOW - 1) / WINDOW;
  localparam int unsigned RECIP_W = SHIFT - LOG_W + 2;
  localparam int unsigned PROD_W = SUM_W + RECIP_W;

  logic [11:0]        win_r [WINDOW];
  logic [SUM_W-1:0]   sum_r;
  logic [SUM_W-1:0]   sum_nxt;
  logic [11:0]        avg_r;
  logic [PROD_W-1:0]  prod;

  // Oldest reading leaves, the new one enters.
  assign sum_nxt = (sum_r - SUM_W'(win_r[WINDOW-1])) + SUM_W'(sample_in);

  // Divide by the window length through a multiply and a shift.
  assign prod          = PROD_W'(sum_nxt) * PROD_W'(RECIP);
  assign avg_level_nxt = prod[SHIFT +: 12];
  assign avg_level     = avg_r;

  // Shift line of readings.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) begin
        win_r[i] <= 12'd0;
      end
    end else if (shift_en) begin
      win_r[0] <= sample_in;
      for (int i = 1; i < WINDOW; i++) begin
        win_r[i] <= win_r[i-1];
      end
    end
  end

  // Running sum and the average it gives.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      avg_r <= THRESHOLD_RST;
    end else if (shift_en) begin
      sum_r <= sum_nxt;
      avg_r <= avg_level_nxt;
    end
  end

endmodule

/* rtl/day_night_mode_controller.sv */
// Day/night mode controller. Each item waits in the input register until the
// output register is free or drains, and its result is then registered there.
// One item is accepted in every cycle when the result side keeps up. The
// one-pass logic between those registers (running sum of the
// light window, a constant reciprocal multiply for the average, the mode
// decision and the schedule distance reduction) sets that rate. There is no
// clearing pass after reset. Configuration registers take writes at any time
// through cfg_*, indexes beyond the register list are ignored, and they must
// only be written while no item is in flight.
`include "assert_macros.svh"

module day_night_mode_controller
  import dnmc_pkg::*;
#(
  parameter int unsigned WINDOW = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input items
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  // Result items
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  // Configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic [11:0] threshold_r;
  logic [10:0] day_start_r;
  logic [10:0] night_start_r;
  logic [7:0]  day_bright_r;
  logic [7:0]  night_bright_r;
  logic [11:0] day_speed_r;
  logic [11:0] night_speed_r;
  logic [15:0] holdoff_r;

  // Pipeline registers and mode state.
  in_item_t    in_r;
  logic        in_vld_r;
  out_item_t   out_r;
  out_item_t   out_nxt;
  logic        out_vld_r;
  logic        night_r;
  logic        night_nxt;
  logic        sched_night_r;
  logic        sched_night_nxt;
  logic [31:0] last_change_r;
  logic [31:0] last_change_nxt;

  logic        advance;
  logic        light_item;
  logic [11:0] avg_level;
  logic [11:0] avg_level_nxt;
  logic [31:0] elapsed;
  logic        holdoff_ok;
  logic [10:0] cur_minute;
  logic [10:0] to_day;
  logic [10:0] to_night;

  // Handshake: an item moves to the output register when it is free or drains.
  assign advance    = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready   = !in_vld_r || advance;
  assign out_valid  = out_vld_r;
  assign out_data   = out_r;
  assign cfg_ready  = 1'b1;
  assign light_item = (in_r.action == ACT_LIGHT);

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r    <= THRESHOLD_RST;
      day_start_r    <= DAY_START_RST;
      night_start_r  <= NIGHT_START_RST;
      day_bright_r   <= DAY_BRIGHT_RST;
      night_bright_r <= NIGHT_BRIGHT_RST;
      day_speed_r    <= DAY_SPEED_RST;
      night_speed_r  <= NIGHT_SPEED_RST;
      holdoff_r      <= HOLDOFF_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LIGHT_THRESHOLD:    threshold_r    <= cfg_data[11:0];
        REG_DAY_START_MINUTE:   day_start_r    <= cfg_data[10:0];
        REG_NIGHT_START_MINUTE: night_start_r  <= cfg_data[10:0];
        REG_DAY_BRIGHTNESS:     day_bright_r   <= cfg_data[7:0];
        REG_NIGHT_BRIGHTNESS:   night_bright_r <= cfg_data[7:0];
        REG_DAY_SPEED:          day_speed_r    <= cfg_data[11:0];
        REG_NIGHT_SPEED:        night_speed_r  <= cfg_data[11:0];
        REG_HOLDOFF_MS:         holdoff_r      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  // Light window; it shifts only for light items.
  dnmc_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk           (clk),
    .rst_n         (rst_n),
    .shift_en      (advance && light_item),
    .sample_in     (in_r.sample),
    .avg_level     (avg_level),
    .avg_level_nxt (avg_level_nxt)
  );

  // Holdoff and schedule distances.
  assign elapsed    = in_r.now_ms - last_change_r;
  assign holdoff_ok = elapsed > 32'(holdoff_r);
  assign cur_minute = minute_of_day(in_r.hour, in_r.minute);
  assign to_day     = dist_to(day_start_r, cur_minute);
  assign to_night   = dist_to(night_start_r, cur_minute);

  // Mode decision and result assembly.
  always_comb begin
    night_nxt       = night_r;
    sched_night_nxt = sched_night_r;
    last_change_nxt = last_change_r;
    out_nxt         = '0;
    if (light_item) begin
      if (holdoff_ok) begin
        if ((avg_level_nxt < threshold_r) && !night_r) begin
          night_nxt       = 1'b1;
          last_change_nxt = in_r.now_ms;
        end else if (!sched_night_r && (avg_level_nxt >= threshold_r) && night_r) begin
          night_nxt       = 1'b0;
          last_change_nxt = in_r.now_ms;
        end
      end
      out_nxt.average_level      = avg_level_nxt;
      out_nxt.next_check_minutes = 11'd0;
    end else begin
      sched_night_nxt            = to_day < to_night;
      night_nxt                  = sched_night_nxt || (avg_level > threshold_r);
      out_nxt.average_level      = avg_level;
      out_nxt.next_check_minutes = night_nxt ? to_day : to_night;
    end
    out_nxt.night_mode      = night_nxt;
    out_nxt.mode_changed    = night_nxt != night_r;
    out_nxt.brightness      = night_nxt ? night_bright_r : day_bright_r;
    out_nxt.speed_factor    = night_nxt ? night_speed_r : day_speed_r;
    out_nxt.scheduled_night = sched_night_nxt;
  end

  // Mode state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      night_r       <= 1'b0;
      sched_night_r <= 1'b0;
      last_change_r <= 32'd0;
    end else if (advance) begin
      night_r       <= night_nxt;
      sched_night_r <= sched_night_nxt;
      last_change_r <= last_change_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  // A scheduled night always forces night mode, and only light items move
  // the change timestamp; mode state moves only when an item completes.
  `ASSERT_IMPLIES(a_sched_forces_night, sched_night_r, night_r,
                  "scheduled night without night mode")
  `ASSERT_NEXT(a_sched_keeps_stamp, advance && !light_item, $stable(last_change_r),
               "schedule item moved the change timestamp")
  `ASSERT_NEXT(a_state_holds, !advance,
               $stable(night_r) && $stable(sched_night_r) && $stable(last_change_r),
               "mode state changed without an item")

endmodule
